FILE: rtl/infix_to_postfix_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix-to-postfix converter
// Shared property forms used at the end of the itp_datapath module.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied
`define ITP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itp assertion failed");

// Next-cycle implication, disabled while reset is applied
`define ITP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itp assertion failed");

`endif

FILE: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Constants, codes and controller/datapath bundles of the infix-to-postfix
// converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Operator stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int CHAR_W      = 8;

  // ASCII codes of the special characters
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;

  // Operator precedence ranks
  localparam logic [1:0] RANK_PAREN  = 2'd0;
  localparam logic [1:0] RANK_ADDSUB = 2'd1;
  localparam logic [1:0] RANK_MULDIV = 2'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CLS_OP    = 2'd0,
    CLS_LPAR  = 2'd1,
    CLS_RPAR  = 2'd2,
    CLS_OTHER = 2'd3
  } cls_t;

  // Source of an emitted result
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_TOP  = 2'd1,
    SEL_CHAR = 2'd2
  } emit_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      set_err;
    logic      clr_err;
    logic      emit;
    logic      finish;
    emit_sel_t sel;
    status_t   status;
  } itp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    cls_t cls;
    logic last;
    logic err_seen;
    logic stack_empty;
    logic stack_full;
    logic top_is_lpar;
    logic pop_ok;
    logic out_free;
  } itp_sts_t;

  function automatic logic [1:0] rank_of(input logic [CHAR_W-1:0] c);
    logic [1:0] r;
    r = RANK_PAREN;
    unique case (c) inside
      CH_PLUS, CH_MINUS: r = RANK_ADDSUB;
      CH_MUL, CH_DIV:    r = RANK_MULDIV;
      default:           r = RANK_PAREN;
    endcase
    return r;
  endfunction

  function automatic cls_t class_of(input logic [CHAR_W-1:0] c);
    cls_t k;
    k = CLS_OTHER;
    unique case (c) inside
      CH_PLUS, CH_MINUS, CH_MUL, CH_DIV: k = CLS_OP;
      CH_LPAR:                           k = CLS_LPAR;
      CH_RPAR:                           k = CLS_RPAR;
      default:                           k = CLS_OTHER;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/itp_if.sv
// ----------------------------------------------------------------------------
// itp_in_if / itp_out_if
// Valid/ready channels carrying infix characters in and postfix results out.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic                       valid;
  logic                       ready;
  logic [itp_pkg::CHAR_W-1:0] char_in;
  logic                       expr_end;

  modport source (output valid, char_in, expr_end, input ready);
  modport sink   (input valid, char_in, expr_end, output ready);
endinterface

interface itp_out_if;
  logic                       valid;
  logic                       ready;
  logic [itp_pkg::CHAR_W-1:0] char_out;
  logic                       has_char;
  itp_pkg::status_t           status;
  logic                       run_last;
  logic                       expr_done;

  modport source (output valid, char_out, has_char, status, run_last, expr_done,
                  input ready);
  modport sink   (input valid, char_out, has_char, status, run_last, expr_done,
                  output ready);
endinterface

FILE: rtl/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/itp_datapath.sv
// ----------------------------------------------------------------------------
// itp_datapath
// Input latch, operator stack (cached top plus RAM), staging slot for the
// newest result, and the output register.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_unit_assert.svh"

module itp_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  itp_pkg::itp_cmd_t          cmd,
  output itp_pkg::itp_sts_t          sts,
  input  logic [itp_pkg::CHAR_W-1:0] in_char_in,
  input  logic                       in_expr_end,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [itp_pkg::CHAR_W-1:0] out_char_out,
  output logic                       out_has_char,
  output itp_pkg::status_t           out_status,
  output logic                       out_run_last,
  output logic                       out_expr_done
);
  import itp_pkg::*;

  // Current item
  logic [CHAR_W-1:0] char_r;
  logic              last_r;

  // Stack: top entry in flops, entries below it in RAM
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CHAR_W-1:0] top_r, top_eff;
  logic              popped_r;
  logic              err_r, err_nxt;
  logic [CHAR_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  wr_cnt, rd_cnt;
  logic              ram_we;

  // Result staging and output register
  logic              stage_valid_r, stage_valid_nxt;
  logic [CHAR_W-1:0] stage_char_r;
  logic              stage_has_r;
  status_t           stage_status_r;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, o_char_nxt;
  logic              out_has_r, o_has_nxt;
  status_t           out_status_r, o_status_nxt;
  logic              out_last_r, o_last_nxt;
  logic              out_done_r, o_done_nxt;
  logic              out_load;
  logic              out_free;

  // New result record
  logic [CHAR_W-1:0] rec_char;
  logic              rec_has;

  // After a pop the new top arrives from the RAM read port
  assign top_eff = popped_r ? ram_rdata : top_r;
  assign out_free = !out_valid_r || out_ready;

  // Spill the old top on a push; keep reading the entry below the top
  assign wr_cnt = count_r - CNT_W'(1);
  assign rd_cnt = count_r - CNT_W'(2);
  assign ram_we = cmd.push && (count_r != '0);

  itp_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_cnt[PTR_W-1:0]),
    .wdata (top_eff),
    .raddr (rd_cnt[PTR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Status toward the controller
  always_comb begin
    sts.cls         = class_of(char_r);
    sts.last        = last_r;
    sts.err_seen    = err_r;
    sts.stack_empty = (count_r == '0);
    sts.stack_full  = (count_r == CNT_W'(STACK_DEPTH));
    sts.top_is_lpar = (top_eff == CH_LPAR);
    sts.pop_ok      = (rank_of(char_r) <= rank_of(top_eff));
    sts.out_free    = out_free;
  end

  // Stack depth and error flag
  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
    err_nxt = err_r;
    if (cmd.set_err) begin
      err_nxt = 1'b1;
    end else if (cmd.clr_err) begin
      err_nxt = 1'b0;
    end
  end

  // Build the record of a new result
  always_comb begin
    rec_char = '0;
    rec_has  = 1'b0;
    unique case (cmd.sel)
      SEL_TOP: begin
        rec_char = top_eff;
        rec_has  = 1'b1;
      end
      SEL_CHAR: begin
        rec_char = char_r;
        rec_has  = 1'b1;
      end
      SEL_NONE: begin
        rec_char = '0;
        rec_has  = 1'b0;
      end
      default: begin
        rec_char = '0;
        rec_has  = 1'b0;
      end
    endcase
  end

  // Advance staging slot into the output register; mark the last on finish
  always_comb begin
    stage_valid_nxt = stage_valid_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_load        = 1'b0;
    o_char_nxt      = stage_char_r;
    o_has_nxt       = stage_has_r;
    o_status_nxt    = stage_status_r;
    o_last_nxt      = 1'b0;
    o_done_nxt      = 1'b0;
    if (cmd.emit) begin
      stage_valid_nxt = 1'b1;
      out_load        = stage_valid_r;
    end else if (cmd.finish) begin
      stage_valid_nxt = 1'b0;
      if (stage_valid_r) begin
        out_load   = 1'b1;
        o_last_nxt = 1'b1;
        o_done_nxt = last_r;
      end else if (last_r) begin
        out_load     = 1'b1;
        o_char_nxt   = '0;
        o_has_nxt    = 1'b0;
        o_status_nxt = ST_OK;
        o_last_nxt   = 1'b1;
        o_done_nxt   = 1'b1;
      end
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      err_r         <= 1'b0;
      popped_r      <= 1'b0;
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      err_r         <= err_nxt;
      popped_r      <= cmd.pop;
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char_in;
      last_r <= in_expr_end;
    end
    top_r <= cmd.push ? char_r : top_eff;
    if (cmd.emit) begin
      stage_char_r   <= rec_char;
      stage_has_r    <= rec_has;
      stage_status_r <= cmd.status;
    end
    if (out_load) begin
      out_char_r   <= o_char_nxt;
      out_has_r    <= o_has_nxt;
      out_status_r <= o_status_nxt;
      out_last_r   <= o_last_nxt;
      out_done_r   <= o_done_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_has_char  = out_has_r;
  assign out_status    = out_status_r;
  assign out_run_last  = out_last_r;
  assign out_expr_done = out_done_r;

  // Checks
  `ITP_ASSERT_IMP(a_push_room, clk, rst_n, cmd.push, count_r < CNT_W'(STACK_DEPTH))
  `ITP_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop, count_r != '0)
  `ITP_ASSERT_IMP(a_out_slot_free, clk, rst_n, out_load, out_free)
  `ITP_ASSERT_IMP(a_err_stack_empty, clk, rst_n, err_r, count_r == '0)
  `ITP_ASSERT_NXT(a_emit_fills_stage, clk, rst_n, cmd.emit, stage_valid_r)

endmodule

FILE: rtl/itp_controller.sv
// ----------------------------------------------------------------------------
// itp_controller
// Sequencer of the shunting-yard steps: decode, pop-while-higher-or-equal, push,
// pop-to-paren, end-of-expression flush and result finish.
// ----------------------------------------------------------------------------
module itp_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  itp_pkg::itp_sts_t sts,
  output itp_pkg::itp_cmd_t cmd
);
  import itp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_OPPOP  = 6'b000100,
    S_PUSH   = 6'b001000,
    S_PAREN  = 6'b010000,
    S_END    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.sel    = SEL_NONE;
    cmd.status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.err_seen) begin
          // skip to the end of a broken expression, then report it once
          if (!sts.last) begin
            state_nxt = S_IDLE;
          end else if (sts.out_free) begin
            cmd.emit    = 1'b1;
            cmd.status  = ST_UNDERFLOW;
            cmd.clr_err = 1'b1;
            state_nxt   = S_END;
          end
        end else begin
          unique case (sts.cls)
            CLS_OP:   state_nxt = S_OPPOP;
            CLS_LPAR: state_nxt = S_PUSH;
            CLS_RPAR: state_nxt = S_PAREN;
            CLS_OTHER: begin
              if (sts.out_free) begin
                cmd.emit  = 1'b1;
                cmd.sel   = SEL_CHAR;
                state_nxt = S_END;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_OPPOP: begin
        // pop operators of equal or higher rank
        if (!sts.stack_empty && sts.pop_ok) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_TOP;
            cmd.pop  = 1'b1;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (sts.stack_full) begin
          if (sts.out_free) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_FULL;
            state_nxt  = S_END;
          end
        end else begin
          cmd.push  = 1'b1;
          state_nxt = S_END;
        end
      end
      S_PAREN: begin
        if (sts.stack_empty) begin
          // unmatched close paren
          if (sts.out_free) begin
            cmd.emit    = 1'b1;
            cmd.status  = ST_UNDERFLOW;
            cmd.set_err = !sts.last;
            state_nxt   = S_END;
          end
        end else if (sts.top_is_lpar) begin
          cmd.pop   = 1'b1;
          state_nxt = S_END;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_TOP;
          cmd.pop  = 1'b1;
        end
      end
      S_END: begin
        // flush the stack at the end of the expression, then close the item
        if (sts.out_free) begin
          if (sts.last && !sts.stack_empty) begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_TOP;
            cmd.pop  = 1'b1;
          end else begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one infix character per item (char_in) and expr_end, set
//          on the final character of an expression.
//   out_ch carries results: char_out/has_char, a status code (ok, underflow
//          on an unmatched ')', full stack), run_last on the last result of
//          an input item and expr_done on the last result of the expression.
//   An item may give no result, one, or up to STACK_DEPTH + 1 results.
// Timing:
//   The block works on one item at a time: it latches the item, decodes it,
//   pops and pushes the stack as the item needs (items after an underflow
//   are skipped up to expr_end), flushes the stack at expr_end and closes
//   the item before it is ready again. The stack gives one pop per cycle
//   through the stack RAM read port while the output slot is free. The
//   newest result waits in a staging slot until the next one or the end of
//   the item, then moves into the output register.
// Reset: synchronous, active low; the stack is empty and no result pending.
// Stall: while out_ch is not ready, the held result stays and the sequencer
//   waits on each new result; a new input item is still taken when idle.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit (
  input  logic              clk,
  input  logic              rst_n,
  itp_in_if.sink            in_ch,
  itp_out_if.source         out_ch
);
  import itp_pkg::*;

  itp_cmd_t cmd;
  itp_sts_t sts;

  itp_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itp_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_char_in    (in_ch.char_in),
    .in_expr_end   (in_ch.expr_end),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_char_out  (out_ch.char_out),
    .out_has_char  (out_ch.has_char),
    .out_status    (out_ch.status),
    .out_run_last  (out_ch.run_last),
    .out_expr_done (out_ch.expr_done)
  );

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Infix-to-postfix converter testbench
// Feeds infix characters through the input channel and checks every postfix
// result against an in-bench shunting-yard predictor. Directed expressions
// come first, then random well-formed, deeply nested, broken and noise
// sequences, with random idling on both channels, a long receiver hold-off
// and a full drain pause.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int NUM_ITEMS   = 260;
  localparam int IDLE_PCT    = 22;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2 * STACK_DEPTH + 16;
  localparam int MAX_LINES   = 50;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } infix_item_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              has;
    status_t           st;
    logic              run_last;
    logic              done;
  } postfix_res_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  itp_in_if  in_if ();
  itp_out_if out_if ();

  infix_to_postfix_converter_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Stimulus and expectation stores
  infix_item_t  infix_q [$];
  postfix_res_t postfix_q [$];

  // Predictor state
  logic [CHAR_W-1:0] op_stk [STACK_DEPTH];
  int                stk_cnt = 0;
  bit                stk_err = 1'b0;

  // Bookkeeping
  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int fail_cnt     = 0;
  int res_cnt      = 0;
  bit steady       = 1'b0;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Known input values before the first edge
  initial begin
    in_if.valid    = 1'b0;
    in_if.char_in  = '0;
    in_if.expr_end = 1'b0;
    out_if.ready   = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic int prec_of(input logic [CHAR_W-1:0] c);
    case (c)
      CH_LPAR, CH_RPAR:  return 0;
      CH_PLUS, CH_MINUS: return 1;
      CH_MUL, CH_DIV:    return 3;
      default:           return -1;
    endcase
  endfunction

  function automatic postfix_res_t make_res(input logic [CHAR_W-1:0] c, input logic has,
                                            input status_t st);
    postfix_res_t r;
    r.ch       = has ? c : '0;
    r.has      = has;
    r.st       = st;
    r.run_last = 1'b0;
    r.done     = 1'b0;
    return r;
  endfunction

  // Work out the results of one accepted item and queue them
  task automatic predict_postfix(input logic [CHAR_W-1:0] c, input logic last);
    postfix_res_t res [$];
    bit           matched;
    matched = 1'b0;
    if (stk_err) begin
      // Drop everything until the end of the broken expression
      if (last) begin
        stk_err = 1'b0;
        stk_cnt = 0;
        res.push_back(make_res('0, 1'b0, ST_UNDERFLOW));
        res[0].done = 1'b1;
      end
    end else begin
      case (c)
        CH_PLUS, CH_MINUS, CH_MUL, CH_DIV: begin
          while (stk_cnt > 0 && prec_of(c) <= prec_of(op_stk[stk_cnt-1])) begin
            stk_cnt--;
            res.push_back(make_res(op_stk[stk_cnt], 1'b1, ST_OK));
          end
          if (stk_cnt >= STACK_DEPTH) begin
            res.push_back(make_res('0, 1'b0, ST_FULL));
          end else begin
            op_stk[stk_cnt] = c;
            stk_cnt++;
          end
        end
        CH_LPAR: begin
          if (stk_cnt >= STACK_DEPTH) begin
            res.push_back(make_res('0, 1'b0, ST_FULL));
          end else begin
            op_stk[stk_cnt] = c;
            stk_cnt++;
          end
        end
        CH_RPAR: begin
          while (stk_cnt > 0 && !matched) begin
            stk_cnt--;
            if (op_stk[stk_cnt] == CH_LPAR) matched = 1'b1;
            else res.push_back(make_res(op_stk[stk_cnt], 1'b1, ST_OK));
          end
          if (!matched) begin
            res.push_back(make_res('0, 1'b0, ST_UNDERFLOW));
            stk_cnt = 0;
            if (!last) stk_err = 1'b1;
          end
        end
        default: res.push_back(make_res(c, 1'b1, ST_OK));
      endcase
      // Flush the stack at the end of the expression
      if (last && !stk_err) begin
        while (stk_cnt > 0) begin
          stk_cnt--;
          res.push_back(make_res(op_stk[stk_cnt], 1'b1, ST_OK));
        end
        if (res.size() == 0) res.push_back(make_res('0, 1'b0, ST_OK));
        res[res.size()-1].done = 1'b1;
      end
    end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[i]) postfix_q.push_back(res[i]);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (fail_cnt < MAX_LINES) $display("ERROR @%0t: %s", $realtime, msg);
    fail_cnt++;
  endtask

  task automatic check_result();
    postfix_res_t e;
    if (postfix_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result ch=%02h has=%0b st=%0d last=%0b done=%0b",
                                out_if.char_out, out_if.has_char, out_if.status,
                                out_if.run_last, out_if.expr_done));
    end else begin
      e = postfix_q.pop_front();
      if (out_if.char_out !== e.ch || out_if.has_char !== e.has ||
          out_if.status !== e.st || out_if.run_last !== e.run_last ||
          out_if.expr_done !== e.done)
        report_mismatch({
          $sformatf("result %0d: got ch=%02h has=%0b st=%0d last=%0b done=%0b",
                    res_cnt, out_if.char_out, out_if.has_char, out_if.status,
                    out_if.run_last, out_if.expr_done),
          $sformatf(", exp ch=%02h has=%0b st=%0d last=%0b done=%0b",
                    e.ch, e.has, e.st, e.run_last, e.done)});
    end
    res_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer pending items, predict on acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_in
    infix_item_t nxt;
    if (!rst_n) begin
      in_if.valid    <= 1'b0;
      in_if.char_in  <= '0;
      in_if.expr_end <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_postfix(in_if.char_in, in_if.expr_end);
        accepted_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (infix_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = infix_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.char_in  <= nxt.ch;
          in_if.expr_end <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random ready, hold-off on request, check each accepted result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_char(input logic [CHAR_W-1:0] c, input logic last);
    infix_item_t it;
    it.ch   = c;
    it.last = last;
    infix_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic offer_expr(input logic [CHAR_W-1:0] s [$]);
    foreach (s[i]) queue_char(s[i], i == s.size() - 1);
  endtask

  task automatic offer_text(input string txt);
    logic [CHAR_W-1:0] s [$];
    for (int i = 0; i < txt.len(); i++) s.push_back(txt[i]);
    offer_expr(s);
  endtask

  function automatic logic [CHAR_W-1:0] rand_operand();
    if ($urandom_range(1)) return CHAR_W'(8'h61 + $urandom_range(25));
    return CHAR_W'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_op();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_MUL;
      default: return CH_DIV;
    endcase
  endfunction

  // Build a well-formed expression, optionally broken by an extra closing
  // parenthesis or a deleted character
  task automatic gen_expr(input int max_ops, input int max_nest, input bit broken);
    logic [CHAR_W-1:0] s [$];
    int                depth;
    int                ops;
    int                n_ops;
    int                pos;
    bit                want_opnd;
    depth     = 0;
    ops       = 0;
    want_opnd = 1'b1;
    n_ops     = $urandom_range(max_ops);
    forever begin
      if (want_opnd) begin
        if (depth < max_nest && $urandom_range(99) < 25) begin
          s.push_back(CH_LPAR);
          depth++;
        end else begin
          s.push_back(rand_operand());
          want_opnd = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(99) < 30) begin
        s.push_back(CH_RPAR);
        depth--;
      end else if (ops < n_ops) begin
        s.push_back(rand_op());
        ops++;
        want_opnd = 1'b1;
      end else if (depth > 0) begin
        s.push_back(CH_RPAR);
        depth--;
      end else begin
        break;
      end
    end
    if (broken) begin
      pos = $urandom_range(s.size() - 1);
      if ($urandom_range(1) || s.size() < 2) s.insert(pos, CH_RPAR);
      else s.delete(pos);
    end
    offer_expr(s);
  endtask

  // Nest around the stack depth to hit the full-stack drop and long flushes
  task automatic gen_deep();
    logic [CHAR_W-1:0] s [$];
    int                k;
    bit                paired;
    k      = $urandom_range(STACK_DEPTH + 2, STACK_DEPTH - 2);
    paired = 1'($urandom_range(1));
    for (int i = 0; i < k; i++) begin
      if (paired) begin
        s.push_back(CH_LPAR);
        s.push_back(rand_operand());
        s.push_back(($urandom_range(1)) ? CH_MUL : CH_PLUS);
        i++;
      end else begin
        s.push_back(CH_LPAR);
      end
    end
    s.push_back(rand_operand());
    if ($urandom_range(1)) begin
      s.push_back(rand_op());
      s.push_back(rand_operand());
    end
    repeat ($urandom_range(4)) s.push_back(CH_RPAR);
    s.push_back(rand_operand());
    offer_expr(s);
  endtask

  // Random bytes over the whole character range with random end flags
  task automatic gen_noise();
    repeat ($urandom_range(6, 1))
      queue_char(CHAR_W'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    while (accepted_cnt != queued_cnt || postfix_q.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int expr_idx;
    int pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: precedence, parentheses, extremes, underflow, empty end
    offer_text("a+b*c");
    offer_text("(a-b)/c");
    queue_char(8'h00, 1'b1);
    queue_char(8'hFF, 1'b1);
    offer_text(")xy");
    offer_text("()");
    offer_text("(");
    offer_text(")");
    wait_drained();

    // Random part: hold-off, drain pause and no-idle stretch come early
    expr_idx = 0;
    while (queued_cnt < NUM_ITEMS) begin
      while (infix_q.size() > 12) @(negedge clk);
      if (expr_idx == 2) hold_req++;
      if (expr_idx == 5) wait_drained();
      if (expr_idx == 6) steady = 1'b1;
      if (expr_idx == 10) steady = 1'b0;
      pick = $urandom_range(99);
      if (expr_idx == 1 || expr_idx == 3 || pick < 8) gen_deep();
      else if (pick < 20) gen_expr(6, 3, 1'b1);
      else if (pick < 30) gen_noise();
      else gen_expr(8, 4, 1'b0);
      expr_idx++;
      @(negedge clk);
    end

    // Let everything come out, then a quiet tail
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (postfix_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", postfix_q.size()));
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: infix_to_postfix_converter_unit.f
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_if.sv
rtl/itp_ram.sv
rtl/itp_datapath.sv
rtl/itp_controller.sv
rtl/infix_to_postfix_converter_unit.sv
tb/sv/testbench.sv
